// ===== hw/rtl/assert_macros.svh =====
// assertion macros shared by the list engine rtl
// no dependencies; bodies vanish when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== hw/rtl/illx_pkg.sv =====
// shared types and constants for the indexed linked list engine
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package illx_pkg;

    localparam int DEF_CAPACITY    = 1024;
    localparam int DEF_VALUE_WIDTH = 32;

    localparam int REQ_W    = 2;
    localparam int ITEM_W   = 32;
    localparam int POS_W    = 10;
    localparam int STATUS_W = 2;
    localparam int LEN_W    = 11;

    localparam logic [REQ_W-1:0] REQ_APPEND = 2'd0;
    localparam logic [REQ_W-1:0] REQ_READ   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // link walker status seen by the sequencer
    typedef struct packed {
        logic backward;  // walk follows backward links
        logic last;      // current step is the final one
        logic none;      // target is the head itself (from load inputs)
    } t_walk_stat;

endpackage

`default_nettype wire

// ===== hw/rtl/indexed_linked_list_engine.sv =====
// top level: circular doubly linked list in a node pool, sequencer and rams
// depends on illx_pkg, illx_ram, illx_walker, assert_macros.svh
//
// channel   dir  handshake                  payload
// request   in   start high, busy low       i_req_type, i_item_value, i_position
// result    out  o_done for one cycle       o_read_value, o_status, o_list_length
//
// append: decode, recycled-node pop if any, link, tail update (list not empty)
// read/remove: decode, walk, found; a remove also frees the node (in found if last node)
// steps = min(index, length - index) links walked; one link per cycle
// errors (index out of range, pool full) and the spare request kind skip to report
// reset is synchronous and needs no clearing pass; the node rams start undefined
// results cannot be stalled; busy stays high until the result beat is out
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module indexed_linked_list_engine
    import illx_pkg::*;
#(
    parameter int CAPACITY    = DEF_CAPACITY,
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic [REQ_W-1:0]           i_req_type,
    input  wire logic signed [ITEM_W-1:0]   i_item_value,
    input  wire logic [POS_W-1:0]           i_position,
    output logic                            o_done,
    output logic signed [ITEM_W-1:0]        o_read_value,
    output logic [STATUS_W-1:0]             o_status,
    output logic [LEN_W-1:0]                o_list_length
);

    localparam int AW  = $clog2(CAPACITY);
    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int CW1 = CW + 1;
    localparam int PW  = (CW > POS_W) ? CW : POS_W;
    localparam int VW  = VALUE_WIDTH;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECODE = 4'd1;
    localparam logic [3:0] S_WALK   = 4'd2;
    localparam logic [3:0] S_FOUND  = 4'd3;
    localparam logic [3:0] S_FREE   = 4'd4;
    localparam logic [3:0] S_POP    = 4'd5;
    localparam logic [3:0] S_LINK   = 4'd6;
    localparam logic [3:0] S_TAIL   = 4'd7;
    localparam logic [3:0] S_TAIL2  = 4'd8;
    localparam logic [3:0] S_REPORT = 4'd9;

    // control state
    logic [3:0]    r_state,     n_state;
    logic [AW-1:0] r_first,     n_first;
    logic [CW-1:0] r_count,     n_count;
    logic [CW-1:0] r_fresh,     n_fresh;
    logic [AW-1:0] r_rec_head,  n_rec_head;
    logic [CW-1:0] r_rec_count, n_rec_count;

    // request and working payload
    logic [REQ_W-1:0]    r_kind,   n_kind;
    logic [VW-1:0]       r_value,  n_value;
    logic [POS_W-1:0]    r_pos,    n_pos;
    logic [AW-1:0]       r_cur,    n_cur;
    logic [AW-1:0]       r_new,    n_new;
    logic [AW-1:0]       r_tail,   n_tail;
    logic [ITEM_W-1:0]   r_rv,     n_rv;
    logic [STATUS_W-1:0] r_status, n_status;

    // ram ports
    logic [AW-1:0] rd_addr;
    logic          fwd_we,  bwd_we,  val_we;
    logic [AW-1:0] fwd_waddr, bwd_waddr, val_waddr;
    logic [AW-1:0] fwd_wdata, bwd_wdata;
    logic [VW-1:0] val_wdata;
    logic [AW-1:0] fwd_rdata, bwd_rdata;
    logic [VW-1:0] val_rdata;

    logic        walk_load;
    logic        walk_step;
    t_walk_stat  walk_stat;
    logic [PW-1:0] w_pos_ext;
    logic [AW-1:0] w_link;

    logic signed [63:0]   w_item64;
    logic signed [VW-1:0] w_val_s;
    logic signed [63:0]   w_val64;

    logic [CW:0] w_used;
    logic [CW:0] w_held;

    assign w_pos_ext = PW'(r_pos);
    assign w_link    = walk_stat.backward ? bwd_rdata : fwd_rdata;
    assign w_item64  = 64'(i_item_value);
    assign w_val_s   = val_rdata;
    assign w_val64   = 64'(w_val_s);

    illx_ram #(.WIDTH(VW), .DEPTH(CAPACITY)) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (val_we),
        .i_waddr (val_waddr),
        .i_wdata (val_wdata),
        .i_raddr (rd_addr),
        .o_rdata (val_rdata)
    );

    illx_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_fwd_ram (
        .i_clk   (i_clk),
        .i_we    (fwd_we),
        .i_waddr (fwd_waddr),
        .i_wdata (fwd_wdata),
        .i_raddr (rd_addr),
        .o_rdata (fwd_rdata)
    );

    illx_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_bwd_ram (
        .i_clk   (i_clk),
        .i_we    (bwd_we),
        .i_waddr (bwd_waddr),
        .i_wdata (bwd_wdata),
        .i_raddr (rd_addr),
        .o_rdata (bwd_rdata)
    );

    illx_walker #(.CAPACITY(CAPACITY)) u_walker (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (walk_load),
        .i_step  (walk_step),
        .i_pos   (w_pos_ext[CW-1:0]),
        .i_count (r_count),
        .o_stat  (walk_stat)
    );

    always_comb begin
        n_state     = r_state;
        n_first     = r_first;
        n_count     = r_count;
        n_fresh     = r_fresh;
        n_rec_head  = r_rec_head;
        n_rec_count = r_rec_count;
        n_kind      = r_kind;
        n_value     = r_value;
        n_pos       = r_pos;
        n_cur       = r_cur;
        n_new       = r_new;
        n_tail      = r_tail;
        n_rv        = r_rv;
        n_status    = r_status;

        rd_addr   = r_cur;
        fwd_we    = 1'b0;
        fwd_waddr = r_new;
        fwd_wdata = r_first;
        bwd_we    = 1'b0;
        bwd_waddr = r_new;
        bwd_wdata = r_first;
        val_we    = 1'b0;
        val_waddr = r_new;
        val_wdata = r_value;
        walk_load = 1'b0;
        walk_step = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_kind  = i_req_type;
                    n_value = w_item64[VW-1:0];
                    n_pos   = i_position;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_rv     = '0;
                n_status = ST_OK;
                n_state  = S_REPORT;
                if (r_kind == REQ_APPEND) begin
                    if (r_count == CW'(CAPACITY)) begin
                        n_status = ST_FULL;
                    end else if (r_rec_count != '0) begin
                        // pop the recycle list: its next link arrives in S_POP
                        rd_addr = r_rec_head;
                        n_new   = r_rec_head;
                        n_state = S_POP;
                    end else begin
                        n_new   = r_fresh[AW-1:0];
                        n_fresh = r_fresh + CW'(1);
                        n_state = S_LINK;
                    end
                end else if (r_kind == REQ_READ || r_kind == REQ_REMOVE) begin
                    if (w_pos_ext >= PW'(r_count)) begin
                        n_status = ST_RANGE;
                    end else begin
                        rd_addr   = r_first;
                        n_cur     = r_first;
                        walk_load = 1'b1;
                        n_state   = walk_stat.none ? S_FOUND : S_WALK;
                    end
                end
            end
            S_WALK: begin
                // one link per cycle: the read data addresses the next read
                rd_addr   = w_link;
                n_cur     = w_link;
                walk_step = 1'b1;
                if (walk_stat.last) begin
                    n_state = S_FOUND;
                end
            end
            S_FOUND: begin
                n_state = S_REPORT;
                if (r_kind == REQ_READ) begin
                    n_rv = w_val64[ITEM_W-1:0];
                end else if (r_count == CW'(1)) begin
                    fwd_we      = 1'b1;
                    fwd_waddr   = r_cur;
                    fwd_wdata   = r_rec_head;
                    n_rec_head  = r_cur;
                    n_rec_count = r_rec_count + CW'(1);
                    n_first     = '0;
                    n_count     = '0;
                end else begin
                    // unlink: prev.fwd = next, next.bwd = prev
                    fwd_we    = 1'b1;
                    fwd_waddr = bwd_rdata;
                    fwd_wdata = fwd_rdata;
                    bwd_we    = 1'b1;
                    bwd_waddr = fwd_rdata;
                    bwd_wdata = bwd_rdata;
                    if (r_cur == r_first) begin
                        n_first = fwd_rdata;
                    end
                    n_state = S_FREE;
                end
            end
            S_FREE: begin
                fwd_we      = 1'b1;
                fwd_waddr   = r_cur;
                fwd_wdata   = r_rec_head;
                n_rec_head  = r_cur;
                n_rec_count = r_rec_count + CW'(1);
                n_count     = r_count - CW'(1);
                n_state     = S_REPORT;
            end
            S_POP: begin
                n_rec_head  = fwd_rdata;
                n_rec_count = r_rec_count - CW'(1);
                n_state     = S_LINK;
            end
            S_LINK: begin
                val_we = 1'b1;
                if (r_count == '0) begin
                    fwd_we    = 1'b1;
                    fwd_wdata = r_new;
                    bwd_we    = 1'b1;
                    bwd_wdata = r_new;
                    n_first   = r_new;
                    n_count   = CW'(1);
                    n_state   = S_REPORT;
                end else begin
                    // fetch the tail through the head's backward link
                    rd_addr = r_first;
                    n_state = S_TAIL;
                end
            end
            S_TAIL: begin
                fwd_we    = 1'b1;
                fwd_wdata = r_first;
                bwd_we    = 1'b1;
                bwd_wdata = bwd_rdata;
                n_tail    = bwd_rdata;
                n_state   = S_TAIL2;
            end
            S_TAIL2: begin
                fwd_we    = 1'b1;
                fwd_waddr = r_tail;
                fwd_wdata = r_new;
                bwd_we    = 1'b1;
                bwd_waddr = r_first;
                bwd_wdata = r_new;
                n_count   = r_count + CW'(1);
                n_state   = S_REPORT;
            end
            S_REPORT: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_first     <= '0;
            r_count     <= '0;
            r_fresh     <= '0;
            r_rec_head  <= '0;
            r_rec_count <= '0;
        end else begin
            r_state     <= n_state;
            r_first     <= n_first;
            r_count     <= n_count;
            r_fresh     <= n_fresh;
            r_rec_head  <= n_rec_head;
            r_rec_count <= n_rec_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind   <= n_kind;
        r_value  <= n_value;
        r_pos    <= n_pos;
        r_cur    <= n_cur;
        r_new    <= n_new;
        r_tail   <= n_tail;
        r_rv     <= n_rv;
        r_status <= n_status;
    end

    assign busy          = (r_state != S_IDLE);
    assign o_done        = (r_state == S_REPORT);
    assign o_read_value  = r_rv;
    assign o_status      = r_status;
    assign o_list_length = LEN_W'(r_count);

    // every node taken from the fresh range is either live or recycled
    assign w_used = CW1'(r_fresh);
    assign w_held = CW1'(r_count) + CW1'(r_rec_count);

    `ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= CW'(CAPACITY))
    `ASSERT_IMPLIES(a_pool_balance, i_clk, i_rst_n, r_state == S_IDLE, w_used == w_held)
    `ASSERT_IMPLIES(a_full_on_append, i_clk, i_rst_n, o_done && o_status == ST_FULL, r_kind == REQ_APPEND)
    `ASSERT_NEXT(a_single_beat, i_clk, i_rst_n, o_done, !o_done && !busy)

endmodule

`default_nettype wire

// ===== hw/rtl/illx_ram.sv =====
// generic single write, single read ram with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module illx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/illx_walker.sv =====
// link walker: picks walk direction and step count, then counts steps down
// depends on illx_pkg
`timescale 1ns / 1ps
`default_nettype none

module illx_walker
    import illx_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_load,
    input  wire logic                           i_step,
    input  wire logic [$clog2(CAPACITY+1)-1:0]  i_pos,
    input  wire logic [$clog2(CAPACITY+1)-1:0]  i_count,
    output t_walk_stat                          o_stat
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic          w_backward;
    logic [CW-1:0] w_steps;
    logic [CW-1:0] r_steps;
    logic [CW-1:0] n_steps;
    logic          r_backward;
    logic          n_backward;

    // past half the length the walk goes backward from the head
    assign w_backward = i_pos > (i_count >> 1);
    assign w_steps    = w_backward ? (i_count - i_pos) : i_pos;

    always_comb begin
        n_steps    = r_steps;
        n_backward = r_backward;
        if (i_load) begin
            n_steps    = w_steps;
            n_backward = w_backward;
        end else if (i_step) begin
            n_steps = r_steps - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_steps    <= '0;
            r_backward <= 1'b0;
        end else begin
            r_steps    <= n_steps;
            r_backward <= n_backward;
        end
    end

    assign o_stat.backward = r_backward;
    assign o_stat.last     = (r_steps == CW'(1));
    assign o_stat.none     = (w_steps == '0);

endmodule

`default_nettype wire
